[src/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg
// Types and constants shared by the execute block and its sub-modules.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Byte address of the instruction_count register on the APB port.
  localparam logic [1:0] ADDR_INSTRUCTION_COUNT = 2'h0;

  // Number of words in the data memory; word indexes wrap at this size.
  localparam int DATA_WORDS = 4096;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_write_valid;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic        unknown_instruction;
  } result_t;

endpackage

[src/mse_if.sv]
// ----------------------------------------------------------------------------
// mse_in_if / mse_out_if
// Valid/ready channels for instruction words and execution results.
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface mse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        halted;
  logic        reg_write_valid;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        store_valid;
  logic [31:0] store_address;
  logic [31:0] store_value;
  logic        unknown_instruction;
  modport source (output valid, output next_pc, output halted, output reg_write_valid,
                  output reg_write_index, output reg_write_value, output store_valid,
                  output store_address, output store_value,
                  output unknown_instruction, input ready);
  modport sink (input valid, input next_pc, input halted, input reg_write_valid,
                input reg_write_index, input reg_write_value, input store_valid,
                input store_address, input store_value, input unknown_instruction,
                output ready);
endinterface

[src/mse_ram.sv]
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/mse_alu.sv]
// ----------------------------------------------------------------------------
// mse_alu
// Decodes one instruction against its operands and gives its effects.
// ----------------------------------------------------------------------------
module mse_alu (
  input  logic [31:0]      pc,
  input  logic [31:0]      word,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output mse_pkg::result_t res,
  output logic             is_load
);
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] seq;
  logic [31:0] jtgt;
  logic        wv;
  logic [4:0]  wi;
  logic [31:0] wval;
  logic        unk;
  logic [31:0] npc;

  always_comb begin
    op   = word[31:26];
    fn   = word[5:0];
    sh   = word[10:6];
    imm  = {16'd0, word[15:0]};
    simm = {{16{word[15]}}, word[15:0]};
    seq  = pc + 32'd4;
    jtgt = {seq[31:28], word[25:0], 2'b00};
    wv = 1'b0; wi = word[20:16]; wval = '0; unk = 1'b0; npc = seq;
    is_load = 1'b0;
    res = '0;
    unique case (op)
      mse_pkg::OP_SPECIAL: begin
        wv = 1'b1; wi = word[15:11];
        unique case (fn)
          mse_pkg::FN_ADDU: wval = a + b;
          mse_pkg::FN_AND:  wval = a & b;
          mse_pkg::FN_NOR:  wval = ~(a | b);
          mse_pkg::FN_OR:   wval = a | b;
          mse_pkg::FN_SLTU: wval = {31'd0, a < b};
          mse_pkg::FN_SLL:  wval = b << sh;
          mse_pkg::FN_SRL:  wval = b >> sh;
          mse_pkg::FN_SUBU: wval = a - b;
          mse_pkg::FN_JR: begin wv = 1'b0; npc = a; end
          default: begin wv = 1'b0; unk = 1'b1; end
        endcase
      end
      mse_pkg::OP_ADDIU: begin wv = 1'b1; wval = a + simm; end
      mse_pkg::OP_ANDI:  begin wv = 1'b1; wval = a & imm; end
      mse_pkg::OP_LUI:   begin wv = 1'b1; wval = {word[15:0], 16'd0}; end
      mse_pkg::OP_ORI:   begin wv = 1'b1; wval = a | imm; end
      mse_pkg::OP_SLTIU: begin wv = 1'b1; wval = {31'd0, a < simm}; end
      mse_pkg::OP_LW:    begin wv = 1'b1; is_load = 1'b1; end
      mse_pkg::OP_SW: begin
        res.store_valid = 1'b1; res.store_address = a + simm; res.store_value = b;
      end
      mse_pkg::OP_BEQ: if (a == b) npc = seq + {simm[29:0], 2'b00};
      mse_pkg::OP_BNE: if (a != b) npc = seq + {simm[29:0], 2'b00};
      mse_pkg::OP_J:   npc = jtgt;
      mse_pkg::OP_JAL: begin
        wv = 1'b1; wi = 5'd31; wval = pc + 32'd8; npc = jtgt;
      end
      default: unk = 1'b1;
    endcase
    if (wi == 5'd0) begin
      wv = 1'b0;
      is_load = 1'b0;
    end
    if (unk) begin
      res = '0;
      res.next_pc = pc;
      res.unknown_instruction = 1'b1;
      is_load = 1'b0;
    end else begin
      res.next_pc = npc;
      res.reg_write_valid = wv;
      res.reg_write_index = wv ? wi : 5'd0;
      res.reg_write_value = wv ? wval : 32'd0;
    end
  end
endmodule

[src/mips_subset_execute.sv]
// ----------------------------------------------------------------------------
// mips_subset_execute
// Executes a subset of MIPS32 instructions against a register file and memory.
// ----------------------------------------------------------------------------
// Instruction words arrive on the in channel, one transaction per instruction
// fetched at the current PC; each produces exactly one result transaction on
// the out channel giving the next PC and any register write or store.
// The instruction_count register (APB, address 0) sets the end of the text
// segment; when the PC reaches it the block reports halted and does nothing.
// Throughput is one instruction per cycle while the output is not stalled,
// for all but LW, which holds the input off as it enters the load stage; its
// data word returns from the synchronous data memory in the cycle after the
// address is formed, and the write-back then finishes it. The register file
// is read synchronously at acceptance; results pass the execute stage (LW
// also the load stage) and the output register. A result that the receiver
// stalls stays there while one more instruction may enter execution (two if
// the first is a load); the input then stalls until the output drains.
// Operands are read again every cycle and a write at the same clock edge is
// bypassed, so results reach the following instruction without a bubble.
// After reset the PC is TEXT_START. The register file and data memory are
// cleared by a sweep over all 4096 data memory words, during which no
// instruction is accepted; APB writes are still taken.
// ----------------------------------------------------------------------------
module mips_subset_execute #(
  parameter logic [31:0] TEXT_START = 32'd4194304
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mse_in_if.sink      in_ch,
  mse_out_if.source   out_ch
);
  localparam int AW = $clog2(mse_pkg::DATA_WORDS);

  logic [15:0] instruction_count;
  logic [31:0] pc;

  // Clearing sweep over both memories after reset.
  logic          clearing;
  logic [AW-1:0] clr_idx;

  // Execute stage: an accepted instruction, its operands readable here.
  logic        ex_valid;
  logic [31:0] ex_word;
  // Load completion stage, holding the word index it reads.
  logic          ld_valid;
  logic [AW-1:0] ld_idx;
  mse_pkg::result_t ld_res;
  // Output register.
  logic        o_valid;
  logic        o_valid_next;
  mse_pkg::result_t o_res;
  mse_pkg::result_t o_res_next;

  logic [4:0]  rf_ra, rf_rb;
  logic [31:0] ra_q, rb_q, a, b;
  // Bypass of a register write that lands at the same edge as the read.
  logic        ra_hit, rb_hit;
  logic [31:0] wr_byp;
  logic [31:0] ex_addr;
  logic [AW-1:0] dm_ra;
  logic [31:0] dm_q;
  mse_pkg::result_t alu_res;
  logic        alu_load;
  logic        alu_load_eff;
  logic        halt_now;
  mse_pkg::result_t ex_res;
  logic        ex_go, ld_fire, out_free;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        dm_we;
  logic [AW-1:0] dm_wa;
  logic [31:0] dm_wd;
  logic        accept;

  assign pready = 1'b1;
  assign prdata = (paddr == mse_pkg::ADDR_INSTRUCTION_COUNT)
                  ? {16'd0, instruction_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      instruction_count <= '0;
    end else if (psel && penable && pwrite && paddr == mse_pkg::ADDR_INSTRUCTION_COUNT) begin
      instruction_count <= pwdata[15:0];
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign out_free = !o_valid || out_ch.ready;
  assign ld_fire  = ld_valid && out_free;
  // The execute stage finishes unless a load holds the write-back path or a
  // non-load meets a stalled output; a load moves on into the load stage even then.
  assign ex_go = ex_valid && !ld_valid && (alu_load_eff || out_free);
  // Accept, outside the clearing sweep, when the execute stage is empty or finishing a non-load.
  assign in_ch.ready = !clearing && (!ex_valid || (ex_go && !alu_load_eff));
  assign accept = in_ch.valid && in_ch.ready;

  // Operand read: the new instruction's registers at accept, otherwise those
  // of the instruction waiting in the execute stage, so the read stays current.
  assign rf_ra = accept ? in_ch.instruction_word[25:21] : ex_word[25:21];
  assign rf_rb = accept ? in_ch.instruction_word[20:16] : ex_word[20:16];

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(rf_ra), .rdata(ra_q));
  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(rf_rb), .rdata(rb_q));

  always_ff @(posedge clk) begin
    ra_hit <= rf_we && (rf_wa == rf_ra);
    rb_hit <= rf_we && (rf_wa == rf_rb);
    wr_byp <= rf_wd;
  end

  always_comb begin
    a = ra_hit ? wr_byp : ra_q;
    b = rb_hit ? wr_byp : rb_q;
    if (ex_word[25:21] == 5'd0) a = '0;
    if (ex_word[20:16] == 5'd0) b = '0;
  end

  mse_alu u_alu (
    .pc(pc), .word(ex_word), .a(a), .b(b), .res(alu_res), .is_load(alu_load));

  assign halt_now = (pc == TEXT_START + {14'd0, instruction_count, 2'b00});
  assign alu_load_eff = alu_load && !halt_now;

  always_comb begin
    if (halt_now) begin
      ex_res = '0;
      ex_res.next_pc = pc;
      ex_res.halted = 1'b1;
    end else begin
      ex_res = alu_res;
    end
  end

  // Data memory read: the load address while executing, then held while the
  // load waits for the output register.
  assign ex_addr = a + {{16{ex_word[15]}}, ex_word[15:0]};
  assign dm_ra   = ld_valid ? ld_idx : ex_addr[AW+1:2];

  mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd),
    .raddr(dm_ra), .rdata(dm_q));

  // Register file and data memory writes.
  always_comb begin
    rf_we = 1'b0; rf_wa = '0; rf_wd = '0;
    dm_we = 1'b0; dm_wa = '0; dm_wd = '0;
    if (clearing) begin
      rf_we = 1'b1; rf_wa = clr_idx[4:0];
      dm_we = 1'b1; dm_wa = clr_idx;
    end else if (ld_fire) begin
      rf_we = 1'b1; rf_wa = ld_res.reg_write_index; rf_wd = dm_q;
    end else if (ex_go && !alu_load_eff && !halt_now) begin
      rf_we = alu_res.reg_write_valid;
      rf_wa = alu_res.reg_write_index;
      rf_wd = alu_res.reg_write_value;
      dm_we = alu_res.store_valid;
      dm_wa = alu_res.store_address[AW+1:2];
      dm_wd = alu_res.store_value;
    end
  end

  // Output register: loaded from the execute stage or from a finished load.
  always_comb begin
    o_valid_next = o_valid && !out_ch.ready;
    o_res_next   = o_res;
    if (ex_go && !alu_load_eff) begin
      o_valid_next = 1'b1;
      o_res_next   = ex_res;
    end
    if (ld_fire) begin
      o_valid_next = 1'b1;
      o_res_next   = ld_res;
      o_res_next.reg_write_value = dm_q;
    end
  end

  always_ff @(posedge clk) begin
    o_res <= o_res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= TEXT_START;
      clearing <= 1'b1;
      clr_idx <= '0;
      ex_valid <= 1'b0;
      ld_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(mse_pkg::DATA_WORDS - 1)) clearing <= 1'b0;
      end
      o_valid <= o_valid_next;
      if (ex_go) begin
        pc <= ex_res.next_pc;
        if (alu_load_eff) begin
          ld_valid <= 1'b1;
          ld_res <= ex_res;
          ld_idx <= ex_addr[AW+1:2];
        end
      end
      if (ld_fire) ld_valid <= 1'b0;
      if (accept) ex_valid <= 1'b1;
      else if (ex_go) ex_valid <= 1'b0;
      if (accept) ex_word <= in_ch.instruction_word;
    end
  end

  assign out_ch.valid               = o_valid;
  assign out_ch.next_pc             = o_res.next_pc;
  assign out_ch.halted              = o_res.halted;
  assign out_ch.reg_write_valid     = o_res.reg_write_valid;
  assign out_ch.reg_write_index     = o_res.reg_write_index;
  assign out_ch.reg_write_value     = o_res.reg_write_value;
  assign out_ch.store_valid         = o_res.store_valid;
  assign out_ch.store_address       = o_res.store_address;
  assign out_ch.store_value         = o_res.store_value;
  assign out_ch.unknown_instruction = o_res.unknown_instruction;
endmodule
